// ===== rtl/qom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qom_pkg: shared types and product schedule
// Operand codes, the step descriptor and the fixed sequence of products that
// builds the pending quaternion and the nine rotation-matrix entries.
// ----------------------------------------------------------------------------
package qom_pkg;

  // Operand sources for one serial product
  typedef enum logic [3:0] {
    SRC_DW, SRC_DX, SRC_DY, SRC_DZ,
    SRC_CW, SRC_CX, SRC_CY, SRC_CZ,
    SRC_PW, SRC_PX, SRC_PY, SRC_PZ
  } src_t;

  // One product: a * b, times -1 when neg, times 2 when dbl.
  // diag marks the first product of a diagonal entry (adds 1.0).
  typedef struct packed {
    src_t src_a;
    src_t src_b;
    logic neg;
    logic dbl;
    logic diag;
  } step_t;

  // Control word from the sequencer to the serial MAC
  typedef struct packed {
    logic load;
    logic first;
    logic diag;
    logic neg;
    logic dbl;
  } mac_ctrl_t;

  localparam int N_QSTEPS  = 16;  // four products per quaternion component
  localparam int N_STEPS   = 34;  // plus two per matrix entry
  localparam int STEP_W    = 6;
  localparam int N_QGROUPS = 4;
  localparam int N_GROUPS  = 13;
  localparam int GRP_W     = 4;
  localparam int N_MAT     = 9;

  function automatic step_t mk(src_t a, src_t b, logic neg, logic dbl, logic diag);
    step_t s;
    s.src_a = a;
    s.src_b = b;
    s.neg   = neg;
    s.dbl   = dbl;
    s.diag  = diag;
    return s;
  endfunction

  function automatic step_t qom_step(logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      // w = dw*cw - dx*cx - dy*cy - dz*cz
      6'd0:  s = mk(SRC_DW, SRC_CW, 1'b0, 1'b0, 1'b0);
      6'd1:  s = mk(SRC_DX, SRC_CX, 1'b1, 1'b0, 1'b0);
      6'd2:  s = mk(SRC_DY, SRC_CY, 1'b1, 1'b0, 1'b0);
      6'd3:  s = mk(SRC_DZ, SRC_CZ, 1'b1, 1'b0, 1'b0);
      // x = dw*cx + dx*cw + dy*cz - dz*cy
      6'd4:  s = mk(SRC_DW, SRC_CX, 1'b0, 1'b0, 1'b0);
      6'd5:  s = mk(SRC_DX, SRC_CW, 1'b0, 1'b0, 1'b0);
      6'd6:  s = mk(SRC_DY, SRC_CZ, 1'b0, 1'b0, 1'b0);
      6'd7:  s = mk(SRC_DZ, SRC_CY, 1'b1, 1'b0, 1'b0);
      // y = dw*cy - dx*cz + dy*cw + dz*cx
      6'd8:  s = mk(SRC_DW, SRC_CY, 1'b0, 1'b0, 1'b0);
      6'd9:  s = mk(SRC_DX, SRC_CZ, 1'b1, 1'b0, 1'b0);
      6'd10: s = mk(SRC_DY, SRC_CW, 1'b0, 1'b0, 1'b0);
      6'd11: s = mk(SRC_DZ, SRC_CX, 1'b0, 1'b0, 1'b0);
      // z = dw*cz + dx*cy - dy*cx + dz*cw
      6'd12: s = mk(SRC_DW, SRC_CZ, 1'b0, 1'b0, 1'b0);
      6'd13: s = mk(SRC_DX, SRC_CY, 1'b0, 1'b0, 1'b0);
      6'd14: s = mk(SRC_DY, SRC_CX, 1'b1, 1'b0, 1'b0);
      6'd15: s = mk(SRC_DZ, SRC_CW, 1'b0, 1'b0, 1'b0);
      // m0 = 1 - 2yy - 2zz
      6'd16: s = mk(SRC_PY, SRC_PY, 1'b1, 1'b1, 1'b1);
      6'd17: s = mk(SRC_PZ, SRC_PZ, 1'b1, 1'b1, 1'b0);
      // m1 = 2xy + 2zw
      6'd18: s = mk(SRC_PX, SRC_PY, 1'b0, 1'b1, 1'b0);
      6'd19: s = mk(SRC_PZ, SRC_PW, 1'b0, 1'b1, 1'b0);
      // m2 = 2zx - 2yw
      6'd20: s = mk(SRC_PZ, SRC_PX, 1'b0, 1'b1, 1'b0);
      6'd21: s = mk(SRC_PY, SRC_PW, 1'b1, 1'b1, 1'b0);
      // m3 = 2xy - 2zw
      6'd22: s = mk(SRC_PX, SRC_PY, 1'b0, 1'b1, 1'b0);
      6'd23: s = mk(SRC_PZ, SRC_PW, 1'b1, 1'b1, 1'b0);
      // m4 = 1 - 2zz - 2xx
      6'd24: s = mk(SRC_PZ, SRC_PZ, 1'b1, 1'b1, 1'b1);
      6'd25: s = mk(SRC_PX, SRC_PX, 1'b1, 1'b1, 1'b0);
      // m5 = 2yz + 2xw
      6'd26: s = mk(SRC_PY, SRC_PZ, 1'b0, 1'b1, 1'b0);
      6'd27: s = mk(SRC_PX, SRC_PW, 1'b0, 1'b1, 1'b0);
      // m6 = 2zx + 2yw
      6'd28: s = mk(SRC_PZ, SRC_PX, 1'b0, 1'b1, 1'b0);
      6'd29: s = mk(SRC_PY, SRC_PW, 1'b0, 1'b1, 1'b0);
      // m7 = 2yz - 2xw
      6'd30: s = mk(SRC_PY, SRC_PZ, 1'b0, 1'b1, 1'b0);
      6'd31: s = mk(SRC_PX, SRC_PW, 1'b1, 1'b1, 1'b0);
      // m8 = 1 - 2xx - 2yy
      6'd32: s = mk(SRC_PX, SRC_PX, 1'b1, 1'b1, 1'b1);
      6'd33: s = mk(SRC_PY, SRC_PY, 1'b1, 1'b1, 1'b0);
      default: s = mk(SRC_DW, SRC_CW, 1'b0, 1'b0, 1'b0);
    endcase
    return s;
  endfunction

  // First / last product of its output group
  function automatic logic step_first(logic [STEP_W-1:0] idx);
    if (idx < STEP_W'(N_QSTEPS)) begin
      return idx[1:0] == 2'b00;
    end
    return idx[0] == 1'b0;
  endfunction

  function automatic logic step_last(logic [STEP_W-1:0] idx);
    if (idx < STEP_W'(N_QSTEPS)) begin
      return idx[1:0] == 2'b11;
    end
    return idx[0] == 1'b1;
  endfunction

endpackage

// ===== rtl/qom_serial_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qom_serial_mac: bit-serial multiply-accumulate
// Shifts the multiplier out one bit a cycle and adds the scaled multiplicand
// into a wide accumulator; rounds and saturates the accumulator on demand.
// ----------------------------------------------------------------------------
module qom_serial_mac #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qom_pkg::mac_ctrl_t           ctrl,
  input  logic signed [COMP_WIDTH-1:0] op_a,
  input  logic signed [COMP_WIDTH-1:0] op_b,
  output logic                         done,
  output logic signed [COMP_WIDTH-1:0] result
);

  localparam int PROD_W = (2 * COMP_WIDTH > 2 * FRAC_BITS + 2) ?
                          2 * COMP_WIDTH : 2 * FRAC_BITS + 2;
  localparam int ACC_W  = PROD_W + 4;
  localparam int CNT_W  = $clog2(COMP_WIDTH);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(COMP_WIDTH - 1);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ONE2 = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (COMP_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [ACC_W-1:0]      mcand_r, mcand_nxt;
  logic        [COMP_WIDTH-1:0] mplier_r, mplier_nxt;
  logic        [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                         run_r, run_nxt;

  logic signed [ACC_W-1:0] a_ext;
  logic signed [ACC_W-1:0] a_sc;
  logic signed [ACC_W-1:0] shifted;

  always_comb begin
    a_ext = ACC_W'(op_a);
    a_sc  = ctrl.dbl ? (a_ext <<< 1) : a_ext;
    if (ctrl.neg) begin
      a_sc = -a_sc;
    end

    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;

    if (ctrl.load) begin
      mcand_nxt  = a_sc;
      mplier_nxt = op_b;
      cnt_nxt    = '0;
      run_nxt    = 1'b1;
      if (ctrl.first) begin
        acc_nxt = ctrl.diag ? (HALF + ONE2) : HALF;
      end
    end else if (run_r) begin
      // sign bit of the multiplier carries negative weight
      if (mplier_r[0]) begin
        acc_nxt = (cnt_r == LAST_CNT) ? acc_r - mcand_r : acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + CNT_W'(1);
      if (cnt_r == LAST_CNT) begin
        run_nxt = 1'b0;
      end
    end
  end

  assign done = run_r && (cnt_r == LAST_CNT);

  // Round half up is already in the accumulator; floor, then clamp
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    if (shifted > MAXV) begin
      result = MAXV[COMP_WIDTH-1:0];
    end else if (shifted < MINV) begin
      result = MINV[COMP_WIDTH-1:0];
    end else begin
      result = shifted[COMP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

// ===== rtl/quaternion_orientation_to_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_orientation_to_matrix_top: orientation keeper with matrix output
// Keeps committed and pending orientation quaternions, applies drag deltas
// by Hamilton product and emits the rotation matrix of the pending value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per drag or release.
//   in_kind bit 0 clear = drag, delta in in_delta_*; set = release.
//   A drag forms delta * committed into pending, then sends one output word
//   (out_m0..out_m8, column-major rotation matrix of pending).
//   A release copies pending into committed, with no output word.
//   All values are signed fixed point, FRAC_BITS fraction bits, rounded
//   half up and saturated to COMP_WIDTH bits.
// Schedule:
//   One shared bit-serial multiplier runs 34 products (16 for the
//   quaternion, 18 for the matrix); each product passes through ST_LOAD
//   and ST_MUL, and each group result is rounded and stored in ST_FIN.
//   A drag then waits in ST_DONE for the output register; in_stall is
//   high until ST_IDLE. A release leaves the block in ST_IDLE.
// Stall:
//   The output word sits in its own register. A new item may be accepted
//   while it waits; a finished matrix is held until that word is taken.
// Reset:
//   Synchronous, active low; both quaternions return to identity and the
//   output channel empties.
// ----------------------------------------------------------------------------
module quaternion_orientation_to_matrix_top #(
  parameter int FRAC_BITS  = 14,
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic signed [COMP_WIDTH-1:0] in_delta_w,
  input  logic signed [COMP_WIDTH-1:0] in_delta_x,
  input  logic signed [COMP_WIDTH-1:0] in_delta_y,
  input  logic signed [COMP_WIDTH-1:0] in_delta_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_m0,
  output logic signed [COMP_WIDTH-1:0] out_m1,
  output logic signed [COMP_WIDTH-1:0] out_m2,
  output logic signed [COMP_WIDTH-1:0] out_m3,
  output logic signed [COMP_WIDTH-1:0] out_m4,
  output logic signed [COMP_WIDTH-1:0] out_m5,
  output logic signed [COMP_WIDTH-1:0] out_m6,
  output logic signed [COMP_WIDTH-1:0] out_m7,
  output logic signed [COMP_WIDTH-1:0] out_m8
);

  localparam logic signed [COMP_WIDTH-1:0] ONE = COMP_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  state_t                          state_r;
  logic [qom_pkg::STEP_W-1:0]      step_r;
  logic [qom_pkg::GRP_W-1:0]       grp_r;
  comp_t                           delta_r   [4];
  comp_t                           commit_r  [4];
  comp_t                           pend_r    [4];
  comp_t                           mres_r    [qom_pkg::N_MAT];
  comp_t                           outm_r    [qom_pkg::N_MAT];
  logic                            out_valid_r;

  qom_pkg::step_t     step;
  qom_pkg::mac_ctrl_t mac_ctrl;
  comp_t              op_a, op_b, mac_res;
  logic               mac_done;
  logic               in_acc, out_acc, out_free, out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;

  assign step = qom_pkg::qom_step(step_r);

  function automatic comp_t pick(qom_pkg::src_t s, comp_t d[4], comp_t c[4], comp_t p[4]);
    comp_t v;
    case (s)
      qom_pkg::SRC_DW: v = d[0];
      qom_pkg::SRC_DX: v = d[1];
      qom_pkg::SRC_DY: v = d[2];
      qom_pkg::SRC_DZ: v = d[3];
      qom_pkg::SRC_CW: v = c[0];
      qom_pkg::SRC_CX: v = c[1];
      qom_pkg::SRC_CY: v = c[2];
      qom_pkg::SRC_CZ: v = c[3];
      qom_pkg::SRC_PW: v = p[0];
      qom_pkg::SRC_PX: v = p[1];
      qom_pkg::SRC_PY: v = p[2];
      qom_pkg::SRC_PZ: v = p[3];
      default:         v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a           = pick(step.src_a, delta_r, commit_r, pend_r);
    op_b           = pick(step.src_b, delta_r, commit_r, pend_r);
    mac_ctrl.load  = (state_r == ST_LOAD);
    mac_ctrl.first = qom_pkg::step_first(step_r);
    mac_ctrl.diag  = step.diag;
    mac_ctrl.neg   = step.neg;
    mac_ctrl.dbl   = step.dbl;
  end

  qom_serial_mac #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (mac_done),
    .result (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        commit_r[i] <= (i == 0) ? ONE : '0;
        pend_r[i]   <= (i == 0) ? ONE : '0;
      end
    end else begin
      // raise valid for a new output word, else drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_kind) begin
              commit_r <= pend_r;
            end else begin
              delta_r[0] <= in_delta_w;
              delta_r[1] <= in_delta_x;
              delta_r[2] <= in_delta_y;
              delta_r[3] <= in_delta_z;
              step_r     <= '0;
              grp_r      <= '0;
              state_r    <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (mac_done) begin
            if (qom_pkg::step_last(step_r)) begin
              state_r <= ST_FIN;
            end else begin
              step_r  <= step_r + qom_pkg::STEP_W'(1);
              state_r <= ST_LOAD;
            end
          end
        end
        ST_FIN: begin
          // store the rounded group result: quaternion first, then matrix
          if (grp_r < qom_pkg::GRP_W'(qom_pkg::N_QGROUPS)) begin
            pend_r[grp_r[1:0]] <= mac_res;
          end else begin
            for (int i = 0; i < qom_pkg::N_MAT - 1; i++) begin
              mres_r[i] <= mres_r[i+1];
            end
            mres_r[qom_pkg::N_MAT-1] <= mac_res;
          end
          grp_r <= grp_r + qom_pkg::GRP_W'(1);
          if (step_r == qom_pkg::STEP_W'(qom_pkg::N_STEPS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            step_r  <= step_r + qom_pkg::STEP_W'(1);
            state_r <= ST_LOAD;
          end
        end
        ST_DONE: begin
          // hold the matrix until the output register is free
          if (out_free) begin
            outm_r  <= mres_r;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_m0    = outm_r[0];
  assign out_m1    = outm_r[1];
  assign out_m2    = outm_r[2];
  assign out_m3    = outm_r[3];
  assign out_m4    = outm_r[4];
  assign out_m5    = outm_r[5];
  assign out_m6    = outm_r[6];
  assign out_m7    = outm_r[7];
  assign out_m8    = outm_r[8];

endmodule

// ===== rtl/qom_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qom_check: port-level checks for the orientation block
// Watches the handshakes and the busy/idle pattern seen at the top level.
// ----------------------------------------------------------------------------
module qom_check #(
  parameter int COMP_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_kind,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COMP_WIDTH-1:0] out_m0,
  input logic signed [COMP_WIDTH-1:0] out_m4,
  input logic signed [COMP_WIDTH-1:0] out_m8
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_m0) && $stable(out_m4)
      && $stable(out_m8))
    else $error("output word changed while stalled");

  // a drag keeps the block busy for its computation
  a_drag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_kind |=> in_stall && !$rose(out_valid))
    else $error("drag did not occupy the block");

  // a release leaves the block unstalled in the next cycle
  a_release_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind |=> !in_stall)
    else $error("release left the block busy");

  // reset empties the output channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind quaternion_orientation_to_matrix_top qom_check #(
  .COMP_WIDTH (COMP_WIDTH)
) u_qom_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_m0    (out_m0),
  .out_m4    (out_m4),
  .out_m8    (out_m8)
);
